// ===== src/dpe_pkg.sv =====
`default_nettype none
package dpe_pkg;

  localparam int MaxLetters = 6;
  localparam int LenW       = 3;
  localparam int DigW       = 3;
  localparam int CntW       = 10;

  typedef logic [DigW-1:0]                  digit_t;
  typedef digit_t [MaxLetters-1:0]          digits_t;
  typedef logic [7:0]                       letter_t;
  typedef letter_t [MaxLetters-1:0]         letters_t;
  typedef logic [LenW-1:0]                  len_t;
  typedef logic [CntW-1:0]                  cnt_t;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_NEXT   = 2'd2
  } action_t;

  // control from the sequencer to the digit counter
  typedef struct packed {
    logic restart;
    logic step;
  } cnt_ctl_t;

  function automatic letter_t letter_at(input letters_t letters, input digit_t idx);
    letter_t res;
    res = '0;
    for (int i = 0; i < MaxLetters; i++) begin
      if (idx == DigW'(i)) begin
        res = letters[i];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== src/distinct_permutation_enumerator.sv =====
// Distinct permutation enumerator.
// Input stream: in_tuser carries the action (clear, append, next), in_tdata
// the letter for an append. Clear and append take effect in the transfer
// cycle and give no result; an append to a full word is ignored. A next
// request starts a search that scans one index tuple per cycle, except
// while parked on a hit, through a shared tuple checker and digit counter,
// skipping the tuples before the next distinct arrangement (about 65 on
// average for a six-letter word, up to 46656 tuples over a whole run).
// When the search is exhausted a request answers with found low. Only one
// request is in flight; in_tready is low while searching.
// Output stream: one result per request, held in an output register. While
// the receiver stalls the register holds, the search parks on a qualifying
// tuple, and a further clear or append can still be taken in idle.
// Reset empties the word, zeroes the counter and count, and drops any
// pending result.
`default_nettype none
module distinct_permutation_enumerator import dpe_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] letter
  input  wire  [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // [47:0] sym_0..sym_5, [50:48] out_length,
                                  // [60:51] perm_count, [63:61] zero
  output logic        out_tuser   // [0] found
);

  typedef enum logic {ST_IDLE, ST_SEARCH} state_t;

  state_t   state_r, state_nxt;
  letters_t letters_r, letters_nxt;
  len_t     len_r, len_nxt;
  cnt_t     cnt_r, cnt_nxt;
  logic     out_vld_r, out_vld_nxt;
  letters_t out_syms_r, out_syms_nxt;
  len_t     out_len_r, out_len_nxt;
  cnt_t     out_cnt_r, out_cnt_nxt;
  logic     out_found_r, out_found_nxt;

  cnt_ctl_t ctl;
  digits_t  digits;
  logic     done;
  logic     ok;
  letters_t syms;
  logic     slot_free;
  action_t  action;

  dpe_counter u_counter (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .len    (len_r),
    .digits (digits),
    .done   (done)
  );

  dpe_check u_check (
    .digits  (digits),
    .letters (letters_r),
    .len     (len_r),
    .ok      (ok),
    .syms    (syms)
  );

  assign action    = action_t'(in_tuser);
  assign slot_free = !out_vld_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    letters_nxt   = letters_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_syms_nxt  = out_syms_r;
    out_len_nxt   = out_len_r;
    out_cnt_nxt   = out_cnt_r;
    out_found_nxt = out_found_r;
    ctl           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (action)
            ACT_CLEAR: begin
              letters_nxt = '0;
              len_nxt     = '0;
              cnt_nxt     = '0;
              ctl.restart = 1'b1;
            end
            ACT_APPEND: begin
              if (len_r < LenW'(MaxLetters)) begin
                for (int i = 0; i < MaxLetters; i++) begin
                  if (len_r == LenW'(i)) begin
                    letters_nxt[i] = in_tdata;
                  end
                end
                len_nxt     = len_r + LenW'(1);
                cnt_nxt     = '0;
                ctl.restart = 1'b1;
              end
            end
            ACT_NEXT: begin
              state_nxt = ST_SEARCH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (done) begin
          if (slot_free) begin
            out_vld_nxt   = 1'b1;
            out_syms_nxt  = '0;
            out_len_nxt   = len_r;
            out_cnt_nxt   = cnt_r;
            out_found_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end else if (ok) begin
          // park on the hit until the output register frees up
          if (slot_free) begin
            out_vld_nxt   = 1'b1;
            out_syms_nxt  = syms;
            out_len_nxt   = len_r;
            out_cnt_nxt   = cnt_r + CntW'(1);
            out_found_nxt = 1'b1;
            cnt_nxt       = cnt_r + CntW'(1);
            ctl.step      = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          ctl.step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      letters_r <= '0;
      len_r     <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      letters_r <= letters_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
    out_syms_r  <= out_syms_nxt;
    out_len_r   <= out_len_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_len_r, out_syms_r};
  assign out_tuser  = out_found_r;

endmodule
`default_nettype wire

// ===== src/dpe_counter.sv =====
`default_nettype none
module dpe_counter import dpe_pkg::*; (
  input  wire      clk,
  input  wire      rst_n,
  input  cnt_ctl_t ctl,
  input  len_t     len,
  output digits_t  digits,
  output logic     done
);

  digits_t digits_r, digits_nxt;
  logic    done_r, done_nxt;
  logic    carry;

  // little-endian counter, base len; wraps past the last tuple into done
  always_comb begin
    digits_nxt = digits_r;
    done_nxt   = done_r;
    carry      = 1'b1;
    if (ctl.restart) begin
      digits_nxt = '0;
      done_nxt   = 1'b0;
    end else if (ctl.step) begin
      for (int p = 0; p < MaxLetters; p++) begin
        if (carry && (LenW'(p) < len)) begin
          if (({1'b0, digits_r[p]} + 4'd1) < {1'b0, len}) begin
            digits_nxt[p] = digits_r[p] + DigW'(1);
            carry         = 1'b0;
          end else begin
            digits_nxt[p] = '0;
          end
        end
      end
      if (carry) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= '0;
      done_r   <= 1'b0;
    end else begin
      digits_r <= digits_nxt;
      done_r   <= done_nxt;
    end
  end

  assign digits = digits_r;
  assign done   = done_r;

endmodule
`default_nettype wire

// ===== src/dpe_check.sv =====
`default_nettype none
module dpe_check import dpe_pkg::*; (
  input  digits_t  digits,
  input  letters_t letters,
  input  len_t     len,
  output logic     ok,
  output letters_t syms
);

  // a tuple qualifies when digits are in range, pairwise distinct, and equal
  // letters appear in descending index order (first tuple of each arrangement)
  always_comb begin
    ok = 1'b1;
    for (int p = 0; p < MaxLetters; p++) begin
      if ((LenW'(p) < len) && (digits[p] >= len)) begin
        ok = 1'b0;
      end
    end
    for (int p = 0; p < MaxLetters; p++) begin
      for (int q = p + 1; q < MaxLetters; q++) begin
        if (LenW'(q) < len) begin
          if (digits[p] == digits[q]) begin
            ok = 1'b0;
          end
          if ((letter_at(letters, digits[p]) == letter_at(letters, digits[q])) &&
              (digits[q] >= digits[p])) begin
            ok = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MaxLetters; j++) begin
      syms[j] = (LenW'(j) < len) ? letter_at(letters, digits[j]) : '0;
    end
  end

endmodule
`default_nettype wire
